/* src/sphere_convex_volume_test_assert.svh */
// Assertion macros for the sphere convex volume test block
`ifndef SPHERE_CONVEX_VOLUME_TEST_ASSERT_SVH
`define SPHERE_CONVEX_VOLUME_TEST_ASSERT_SVH
// implication check, reset disables
`define SCV_ASSERT_IMP(lbl, clk, rst_n, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// next-cycle implication check
`define SCV_ASSERT_NXT(lbl, clk, rst_n, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

/* src/scvt_pkg.sv */
// ----------------------------------------------------------------------------
// scvt_pkg
// Shared types and constants for the sphere convex volume test block.
// ----------------------------------------------------------------------------
`default_nettype none
package scvt_pkg;
	localparam int MaxPlanes = 8;
	localparam int IdxW      = $clog2(MaxPlanes);
	localparam int CntW      = $clog2(MaxPlanes + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
	localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
	localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

	localparam logic [0:0] REG_PLANE_COUNT = 1'b0;
	localparam logic [0:0] REG_TOLERANCE   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SUM, ST_SQRT, ST_DIV, ST_STORE,
		ST_TRD, ST_TMUL, ST_TSUM, ST_TCMP, ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic sq;
		logic sum;
		logic sqrt_start;
		logic div_start;
		logic [1:0] div_sel;
		logic store;
		logic rd;
		logic mul;
		logic acc;
		logic cmp;
		logic [IdxW-1:0] plane;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op;
		logic zero_norm;
		logic idx_ok;
		logic sqrt_done;
		logic div_done;
		logic above;
		logic [CntW-1:0] cnt;
	} status_t;
endpackage
`default_nettype wire

/* src/scvt_if.sv */
// ----------------------------------------------------------------------------
// scvt_in_if / scvt_out_if
// Valid/ready channels for input items and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none
interface scvt_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [2:0]         plane_index;
	logic signed [23:0] normal_x;
	logic signed [23:0] normal_y;
	logic signed [23:0] normal_z;
	logic signed [23:0] plane_offset;
	logic signed [23:0] center_x;
	logic signed [23:0] center_y;
	logic signed [23:0] center_z;
	logic [22:0]        radius;
	modport source (output valid, op, plane_index, normal_x, normal_y, normal_z,
		plane_offset, center_x, center_y, center_z, radius, input ready);
	modport sink (input valid, op, plane_index, normal_x, normal_y, normal_z,
		plane_offset, center_x, center_y, center_z, radius, output ready);
endinterface

interface scvt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface
`default_nettype wire

/* src/scvt_sqrt.sv */
// ----------------------------------------------------------------------------
// scvt_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module scvt_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic [31:0]      root,
	output logic             done
);
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [63:0] v_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [65:0] trial;
	logic [65:0] rem_sh;

	// shift in two radicand bits, try subtract 4r+1
	assign rem_sh = {rem_q, v_q[63:62]};
	assign trial  = rem_sh - {32'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			v_q    <= radicand;
		end else if (busy_q) begin
			v_q <= {v_q[61:0], 2'b00};
			if (!trial[65]) begin
				rem_q  <= trial[63:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[63:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule
`default_nettype wire

/* src/scvt_div.sv */
// ----------------------------------------------------------------------------
// scvt_div
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// Computes floor(num / den) for unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none
module scvt_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] num,
	input  wire logic [32:0] den,
	output logic [47:0]      quo,
	output logic             done
);
	logic [47:0] q_q;
	logic [33:0] r_q;
	logic [32:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] r_sh;
	logic [34:0] diff;

	assign r_sh = {r_q[32:0], q_q[47]};
	assign diff = {1'b0, r_sh} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[34]) begin
				r_q <= diff[33:0];
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
`default_nettype wire

/* src/scvt_ctrl.sv */
// ----------------------------------------------------------------------------
// scvt_ctrl
// Sequencer: plane normalization on load, plane sweep on test.
// ----------------------------------------------------------------------------
`default_nettype none
module scvt_ctrl import scvt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t st,
	output cmd_t         cmd
);
	state_t state_q, state_d;
	logic [IdxW:0] pl_q, pl_d;
	logic [1:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pl_q    <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			pl_q    <= pl_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pl_d      = pl_q;
		sel_d     = sel_q;
		cmd       = '0;
		cmd.plane = pl_q[IdxW-1:0];
		cmd.div_sel = sel_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (st.op == OP_TEST) begin
					pl_d = '0;
					state_d = ST_TRD;
				end else begin
					cmd.sq = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_start = 1'b1;
				state_d = ST_DIV;
				sel_d = 2'd0;
			end
			ST_DIV: begin
				if (!st.idx_ok) begin
					state_d = ST_IDLE;
				end else if (st.zero_norm) begin
					state_d = ST_STORE;
				end else if (st.sqrt_done) begin
					cmd.div_start = 1'b1;
				end else if (st.div_done) begin
					if (sel_q == 2'd3) begin
						state_d = ST_STORE;
					end else begin
						sel_d = sel_q + 2'd1;
						cmd.div_sel = sel_q + 2'd1;
						cmd.div_start = 1'b1;
					end
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TRD: begin
				if ({1'b0, pl_q} >= {1'b0, st.cnt}) begin
					state_d = ST_OUT;
				end else begin
					cmd.rd = 1'b1;
					state_d = ST_TMUL;
				end
			end
			ST_TMUL: begin
				cmd.mul = 1'b1;
				state_d = ST_TSUM;
			end
			ST_TSUM: begin
				cmd.acc = 1'b1;
				state_d = ST_TCMP;
			end
			ST_TCMP: begin
				cmd.cmp = 1'b1;
				if (st.above) begin
					state_d = ST_OUT;
				end else begin
					pl_d = pl_q + 1'b1;
					state_d = ST_TRD;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* src/scvt_dp.sv */
// ----------------------------------------------------------------------------
// scvt_dp
// Datapath: item capture, normalization arithmetic, plane store, distance.
// ----------------------------------------------------------------------------
`default_nettype none
module scvt_dp import scvt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 st,
	input  wire logic               op,
	input  wire logic [2:0]         plane_index,
	input  wire logic signed [23:0] normal_x,
	input  wire logic signed [23:0] normal_y,
	input  wire logic signed [23:0] normal_z,
	input  wire logic signed [23:0] plane_offset,
	input  wire logic signed [23:0] center_x,
	input  wire logic signed [23:0] center_y,
	input  wire logic signed [23:0] center_z,
	input  wire logic [22:0]        radius,
	input  wire logic [3:0]         plane_num,
	input  wire logic [7:0]         tolerance,
	output logic [1:0]              verdict
);
	logic op_q;
	logic [2:0] idx_q;
	logic signed [23:0] n_q [3];
	logic signed [23:0] d_q;
	logic [47:0] sq_q [3];
	logic [49:0] s_q;
	logic [32:0] l8_q;
	logic [32:0] l8;
	logic signed [15:0] nn_q [3];
	logic signed [31:0] on_q;
	logic signed [15:0] pn_q [MaxPlanes][3];
	logic signed [31:0] po_q [MaxPlanes];
	logic signed [15:0] rn_s1 [3];
	logic signed [31:0] ro_s1;
	logic signed [40:0] pr_s2 [3];
	logic signed [45:0] ro_s2;
	logic signed [47:0] dist_s3;
	logic signed [47:0] bound_q;
	logic inside_q;
	logic [31:0] root;
	logic sqrt_done, div_done;
	logic [47:0] quo;
	logic [47:0] div_num;
	logic div_neg;
	logic [23:0] mag;
	logic [48:0] rq;

	// capture the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			idx_q <= plane_index;
			n_q[0] <= op ? center_x : normal_x;
			n_q[1] <= op ? center_y : normal_y;
			n_q[2] <= op ? center_z : normal_z;
			d_q   <= plane_offset;
			bound_q <= 48'(({25'd0, radius} + {40'd0, tolerance}) * 48'sd16384);
		end
	end

	// squares, then their sum
	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			for (int k = 0; k < 3; k++) sq_q[k] <= 48'(n_q[k] * n_q[k]);
		end
		if (cmd.sum) s_q <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
	end

	scvt_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start),
		.radicand({s_q[47:0], 16'd0}), .root(root), .done(sqrt_done)
	);

	// normal length: fresh root in its done cycle, held copy after
	assign l8 = sqrt_done ? {1'b0, root} : l8_q;

	// dividend for round(num/L8) as floor((2|num|+L8)/(2L8))
	always_comb begin
		if (cmd.div_sel == 2'd3) begin
			div_neg = d_q[23];
			mag = d_q[23] ? 24'(-d_q) : d_q;
			div_num = {7'd0, mag, 17'd0} + {15'd0, l8};
		end else begin
			div_neg = n_q[cmd.div_sel][23];
			mag = n_q[cmd.div_sel][23] ? 24'(-n_q[cmd.div_sel]) : n_q[cmd.div_sel];
			div_num = {1'b0, mag, 23'd0} + {15'd0, l8};
		end
	end

	logic neg_q;
	logic [1:0] dsel_q;
	always_ff @(posedge clk) begin
		if (sqrt_done) l8_q <= {1'b0, root};
		if (cmd.div_start) begin
			neg_q  <= div_neg;
			dsel_q <= cmd.div_sel;
		end
	end

	scvt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den({l8[31:0], 1'b0}), .quo(quo), .done(div_done)
	);

	// signed quotient, saturated only for the offset
	always_comb begin
		rq = neg_q ? -{1'b0, quo} : {1'b0, quo};
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (dsel_q == 2'd3) begin
				if (!neg_q && quo > 48'h7FFFFFFF) on_q <= 32'sh7FFFFFFF;
				else if (neg_q && quo > 48'h80000000) on_q <= 32'sh80000000;
				else on_q <= rq[31:0];
			end else begin
				nn_q[dsel_q] <= rq[15:0];
			end
		end
	end

	// plane store
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (s_q == '0) begin
				for (int k = 0; k < 3; k++) pn_q[idx_q[IdxW-1:0]][k] <= '0;
				po_q[idx_q[IdxW-1:0]] <= 32'(d_q);
			end else begin
				for (int k = 0; k < 3; k++) pn_q[idx_q[IdxW-1:0]][k] <= nn_q[k];
				po_q[idx_q[IdxW-1:0]] <= on_q;
			end
		end
	end

	// distance pipeline: read, multiply, sum
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			for (int k = 0; k < 3; k++) rn_s1[k] <= pn_q[cmd.plane][k];
			ro_s1 <= po_q[cmd.plane];
		end
		if (cmd.mul) begin
			for (int k = 0; k < 3; k++) pr_s2[k] <= 41'(rn_s1[k] * n_q[k]);
			ro_s2 <= 46'(ro_s1) <<< 14;
		end
		if (cmd.acc) dist_s3 <= 48'(pr_s2[0]) + 48'(pr_s2[1]) + 48'(pr_s2[2]) + 48'(ro_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inside_q <= 1'b1;
		else if (cmd.capture) inside_q <= 1'b1;
		else if (cmd.cmp && !(dist_s3 < -bound_q)) inside_q <= 1'b0;
	end

	logic outside_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) outside_q <= 1'b0;
		else if (cmd.capture) outside_q <= 1'b0;
		else if (cmd.cmp && dist_s3 > bound_q) outside_q <= 1'b1;
	end

	assign verdict = outside_q ? VERDICT_OUTSIDE : (inside_q ? VERDICT_INSIDE : VERDICT_INTERSECT);

	assign st.op        = op_q;
	assign st.zero_norm = (s_q == '0);
	assign st.idx_ok    = ({1'b0, idx_q} < 4'(MaxPlanes));
	assign st.sqrt_done = sqrt_done;
	assign st.div_done  = div_done;
	assign st.above     = (dist_s3 > bound_q);
	assign st.cnt       = (plane_num > 4'(MaxPlanes)) ? CntW'(MaxPlanes) : CntW'(plane_num);
endmodule
`default_nettype wire

/* src/sphere_convex_volume_test.sv */
// Sphere convex volume test, top level.
// Load: capture, square, sum, square root, four serial divisions, store; a zero normal skips the divisions.
// Test: read, multiply, sum and compare for each active plane, stops early on an outside plane.
// One item at a time; the verdict register holds until taken.
// Reset (arst_n, asynchronous): count and tolerance zero, store undefined.
`default_nettype none
module sphere_convex_volume_test import scvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	scvt_in_if.sink          in_ch,
	scvt_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
`include "sphere_convex_volume_test_assert.svh"
	logic [3:0] plane_num_q;
	logic [7:0] tolerance_q;
	cmd_t cmd;
	status_t st;
	logic wr;

	// configuration registers
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_num_q <= '0;
			tolerance_q <= '0;
		end else if (wr && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_PLANE_COUNT) plane_num_q <= pwdata[3:0];
			else tolerance_q <= pwdata[7:0];
		end
	end
	assign prdata = (paddr[2] == REG_PLANE_COUNT) ? {28'd0, plane_num_q}
		: {24'd0, tolerance_q};

	scvt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .st(st), .cmd(cmd)
	);

	scvt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.op(in_ch.op), .plane_index(in_ch.plane_index),
		.normal_x(in_ch.normal_x), .normal_y(in_ch.normal_y), .normal_z(in_ch.normal_z),
		.plane_offset(in_ch.plane_offset), .center_x(in_ch.center_x),
		.center_y(in_ch.center_y), .center_z(in_ch.center_z), .radius(in_ch.radius),
		.plane_num(plane_num_q), .tolerance(tolerance_q), .verdict(out_ch.verdict)
	);

	// never accept and present a verdict in the same cycle
	`SCV_ASSERT_IMP(a_no_overlap, clk, arst_n, in_ch.ready, !out_ch.valid)
	// a presented verdict is always a legal code
	`SCV_ASSERT_IMP(a_verdict_code, clk, arst_n, out_ch.valid, out_ch.verdict == VERDICT_OUTSIDE || out_ch.verdict == VERDICT_INSIDE || out_ch.verdict == VERDICT_INTERSECT)
	// a completed test leaves the controller ready again
	`SCV_ASSERT_NXT(a_done, clk, arst_n, out_ch.valid && out_ch.ready, in_ch.ready)
endmodule
`default_nettype wire

/* test/sphere_convex_volume_test_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphere_convex_volume_test_test
// Self-checking bench for the sphere convex volume test block. Plane loads and
// sphere tests are driven over valid/ready channels under random idling and
// back pressure, registers are set over APB between phases, and every verdict
// is checked against a bit-exact fixed-point model of the plane store.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_convex_volume_test_test import scvt_pkg::*; ();

	localparam int  RandPerPhase = 280;
	localparam int  DrainCycles  = 300;
	localparam int  CycleLimit   = 2000000;
	localparam int  LongHold     = 400;

	typedef struct {
		logic               op;
		logic [2:0]         idx;
		logic signed [23:0] nx, ny, nz, d;
		logic signed [23:0] cx, cy, cz;
		logic [22:0]        r;
	} sphere_item_t;

	// plane store model and expected verdict queue
	class volume_scoreboard;
		longint      nrm [MaxPlanes][3];
		longint      ofs [MaxPlanes];
		int unsigned plane_cnt;
		int unsigned tol;
		logic [1:0]  verdicts_due [$];
		int          errors;
		int          loads, tests;
		int          seen [3];

		function new();
			plane_cnt = 0;
			tol       = 0;
			errors    = 0;
			loads     = 0;
			tests     = 0;
			seen      = '{0, 0, 0};
		endfunction

		function void set_reg(logic [0:0] regi, logic [31:0] val);
			if (regi == REG_PLANE_COUNT)
				plane_cnt = {28'd0, val[3:0]};
			else
				tol = {24'd0, val[7:0]};
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// round half away from zero
		function longint div_round(longint num, longint unsigned den);
			longint unsigned mag, q;
			mag = (num < 0) ? longint'(-num) : num;
			q   = (2 * mag + den) / (2 * den);
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		// called for every accepted input transaction
		function void note(sphere_item_t it);
			longint           n [3];
			longint           c [3];
			longint unsigned  s, l8;
			longint           q, dst, bound;
			int unsigned      cnt;
			bit               all_in;
			logic [1:0]       v;
			if (it.op == OP_LOAD) begin
				loads++;
				if (it.idx >= MaxPlanes)
					return;
				n[0] = longint'(it.nx);
				n[1] = longint'(it.ny);
				n[2] = longint'(it.nz);
				s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
				if (s == 0) begin
					for (int k = 0; k < 3; k++)
						nrm[it.idx][k] = 0;
					ofs[it.idx] = longint'(it.d);
				end else begin
					l8 = int_sqrt(s << 16);
					for (int k = 0; k < 3; k++) begin
						q = div_round(n[k] * 64'sd4194304, l8);
						if (q > 32767)  q = 32767;
						if (q < -32768) q = -32768;
						nrm[it.idx][k] = q;
					end
					q = div_round(longint'(it.d) * 64'sd65536, l8);
					if (q > 64'sd2147483647)  q = 64'sd2147483647;
					if (q < -64'sd2147483648) q = -64'sd2147483648;
					ofs[it.idx] = q;
				end
				return;
			end
			tests++;
			c[0] = longint'(it.cx);
			c[1] = longint'(it.cy);
			c[2] = longint'(it.cz);
			cnt    = (plane_cnt > MaxPlanes) ? MaxPlanes : plane_cnt;
			bound  = (longint'(it.r) + tol) * 16384;
			all_in = 1;
			v      = VERDICT_INSIDE;
			for (int i = 0; i < cnt; i++) begin
				dst = ofs[i] * 16384;
				for (int k = 0; k < 3; k++)
					dst += nrm[i][k] * c[k];
				if (dst > bound) begin
					v = VERDICT_OUTSIDE;
					break;
				end
				if (!(dst < -bound))
					all_in = 0;
			end
			if (v != VERDICT_OUTSIDE)
				v = all_in ? VERDICT_INSIDE : VERDICT_INTERSECT;
			verdicts_due = {verdicts_due, v};
		endfunction

		// called for every accepted output transaction
		function void check(logic [1:0] got);
			logic [1:0] want;
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected verdict %0d", $time, got);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			if (got !== want) begin
				$display("%0t: verdict mismatch expected %0d actual %0d", $time, want, got);
				errors++;
			end
			if (want < 3)
				seen[want]++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	scvt_in_if  in_ch ();
	scvt_out_if out_ch ();

	sphere_convex_volume_test dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	volume_scoreboard sb = new();

	bit quiet;
	bit hold_req;
	int cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// known values before the first edge
	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		in_ch.valid        = 1'b0;
		in_ch.op           = OP_TEST;
		in_ch.plane_index  = '0;
		in_ch.normal_x     = '0;
		in_ch.normal_y     = '0;
		in_ch.normal_z     = '0;
		in_ch.plane_offset = '0;
		in_ch.center_x     = '0;
		in_ch.center_y     = '0;
		in_ch.center_z     = '0;
		in_ch.radius       = '0;
		out_ch.ready       = 1'b0;
		quiet              = 1'b0;
		hold_req           = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout, %0d verdicts still due", $time, sb.verdicts_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end
	initial cycles = 0;

	// transaction monitors
	always @(posedge clk) begin
		sphere_item_t it;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			it.op  = in_ch.op;
			it.idx = in_ch.plane_index;
			it.nx  = in_ch.normal_x;
			it.ny  = in_ch.normal_y;
			it.nz  = in_ch.normal_z;
			it.d   = in_ch.plane_offset;
			it.cx  = in_ch.center_x;
			it.cy  = in_ch.center_y;
			it.cz  = in_ch.center_z;
			it.r   = in_ch.radius;
			sb.note(it);
		end
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check(out_ch.verdict);
	end

	// receiver: random stall bursts, one long hold on request
	always @(posedge clk) begin
		static int stall_left = 0;
		static int hold_left  = 0;
		static bit hold_seen  = 0;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LongHold;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (quiet) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// APB register write, setup then access
	task automatic apb_write(logic [0:0] regi, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regi, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(regi, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait for every verdict, then let a pending load finish
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic configure(int unsigned cnt, int unsigned tl);
		drain();
		apb_write(REG_PLANE_COUNT, cnt);
		apb_write(REG_TOLERANCE, tl);
		@(posedge clk);
	endtask

	// offer one transaction and hold it until accepted, then maybe idle
	task automatic send(sphere_item_t it);
		in_ch.valid        <= 1'b1;
		in_ch.op           <= it.op;
		in_ch.plane_index  <= it.idx;
		in_ch.normal_x     <= it.nx;
		in_ch.normal_y     <= it.ny;
		in_ch.normal_z     <= it.nz;
		in_ch.plane_offset <= it.d;
		in_ch.center_x     <= it.cx;
		in_ch.center_y     <= it.cy;
		in_ch.center_z     <= it.cz;
		in_ch.radius       <= it.r;
		do @(posedge clk); while (!in_ch.ready);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// random signed value of random magnitude width
	function automatic logic signed [23:0] rand_s24();
		logic signed [23:0] t;
		int                 w;
		w = $urandom_range(1, 24);
		t = 24'($urandom);
		t = t <<< (24 - w);
		return t >>> (24 - w);
	endfunction

	function automatic logic [22:0] rand_r23();
		logic [22:0] t;
		t = 23'($urandom);
		return t >> (23 - $urandom_range(1, 23));
	endfunction

	function automatic sphere_item_t mk_load(int idx, int nx, int ny, int nz, int d);
		sphere_item_t it;
		it     = '{default: '0};
		it.op  = OP_LOAD;
		it.idx = 3'(idx);
		it.nx  = 24'(nx);
		it.ny  = 24'(ny);
		it.nz  = 24'(nz);
		it.d   = 24'(d);
		it.cx  = 24'($urandom);
		it.cy  = 24'($urandom);
		it.cz  = 24'($urandom);
		it.r   = 23'($urandom);
		return it;
	endfunction

	function automatic sphere_item_t mk_test(int cx, int cy, int cz, int r);
		sphere_item_t it;
		it    = '{default: '0};
		it.op = OP_TEST;
		it.idx = 3'($urandom);
		it.nx = 24'($urandom);
		it.ny = 24'($urandom);
		it.nz = 24'($urandom);
		it.d  = 24'($urandom);
		it.cx = 24'(cx);
		it.cy = 24'(cy);
		it.cz = 24'(cz);
		it.r  = 23'(r);
		return it;
	endfunction

	function automatic sphere_item_t rand_item();
		if ($urandom_range(0, 9) < 3)
			return mk_load($urandom_range(0, 7), int'(rand_s24()), int'(rand_s24()),
				int'(rand_s24()), int'(rand_s24()));
		return mk_test(int'(rand_s24()), int'(rand_s24()), int'(rand_s24()),
			int'(rand_r23()));
	endfunction

	localparam int SMin = -8388608;
	localparam int SMax = 8388607;
	localparam int RMax = 8388607;

	initial begin
		static int unsigned phase_cnt [6] = '{8, 15, 1, 3, 0, 8};
		static int unsigned phase_tol [6] = '{0, 255, 0, 17, 128, 255};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no active planes: always inside
		send(mk_test(SMax, SMin, 0, 0));
		send(mk_test(SMin, SMax, SMax, RMax));
		// fill the whole store: extremes, zero normal, largest offsets
		send(mk_load(0, SMax, 0, 0, SMin));
		send(mk_load(1, SMin, SMin, SMin, SMax));
		send(mk_load(2, 0, 0, 0, -5));
		send(mk_load(3, 1, 0, 0, SMax));
		send(mk_load(4, 0, -1, 0, SMin));
		send(mk_load(5, 0, 0, SMin, 256));
		send(mk_load(6, 300, -400, 1200, -77));
		send(mk_load(7, -1, 1, -1, 0));
		configure(8, 255);
		send(mk_test(0, 0, 0, 0));
		send(mk_test(0, 0, 0, RMax));
		send(mk_test(SMax, SMax, SMax, 0));
		send(mk_test(SMin, SMin, SMin, RMax));
		send(mk_test(SMin, 0, SMax, 1));
		send(mk_test(1, -1, 1, 255));
		// count above store size clamps
		configure(15, 0);
		send(mk_test(0, 0, 0, RMax));
		send(mk_test(SMax, SMin, SMax, 0));
		configure(1, 255);
		send(mk_test(-256, 0, 0, 0));
		send(mk_test(SMax, 0, 0, 100));

		// random phases
		for (int p = 0; p < 6; p++) begin
			if (p == 4)
				configure($urandom_range(0, 15), $urandom_range(0, 255));
			else
				configure(phase_cnt[p], phase_tol[p]);
			quiet = (p == 5);
			for (int i = 0; i < RandPerPhase; i++) begin
				if (p == 2 && i == 20)
					hold_req = ~hold_req;
				send(rand_item());
			end
		end

		// end of run
		in_ch.valid <= 1'b0;
		while (sb.verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Covered %0d plane loads and %0d sphere tests over several register settings.",
			sb.loads, sb.tests);
		$display("Verdicts seen: outside %0d, inside %0d, intersecting %0d; mismatches %0d.",
			sb.seen[0], sb.seen[1], sb.seen[2], sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
